>>> rtl/pgtl_pkg.sv
// ----------------------------------------------------------------------------
// pgtl_pkg
// shared types, constants and helpers of the priority gated token limiter
// ----------------------------------------------------------------------------
`default_nettype none

package pgtl_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int NUM_CLASSES_DEF = 4;
    localparam int MAX_RESULTS     = 32;

    localparam int TOK_W   = 16;
    localparam int USEC_W  = 20;
    localparam int SEC_W   = 32;
    localparam int CLS_W   = 3;
    localparam int TAG_W   = 8;
    localparam int STAT_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [TOK_W-1:0]  RATE_RST = 16'd1024;
    localparam logic [USEC_W-1:0] THR0_RST = 20'(900 * 1000);
    localparam logic [USEC_W-1:0] THR1_RST = 20'(800 * 1000);
    localparam logic [USEC_W-1:0] THR2_RST = 20'(500 * 1000);
    localparam logic [USEC_W-1:0] THR3_RST = 20'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOKEN_RATE = 3'd0,
        CFG_THR0       = 3'd1,
        CFG_THR1       = 3'd2,
        CFG_THR2       = 3'd3,
        CFG_THR3       = 3'd4
    } cfg_idx_t;

    typedef enum logic [STAT_W-1:0] {
        ST_GRANT_NOW   = 3'd0,
        ST_QUEUED      = 3'd1,
        ST_REJECTED    = 3'd2,
        ST_GRANT_QUEUE = 3'd3,
        ST_NONE        = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        OP_REQ   = 2'd0,
        OP_UNLIM = 2'd1,
        OP_WAKE  = 2'd2
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [SEC_W-1:0]  now_sec;
        logic [USEC_W-1:0] usec;
        logic [CLS_W-1:0]  src_class;
        logic [TOK_W-1:0]  tokens;
        logic [TAG_W-1:0]  req_tag;
    } item_t;

    typedef struct packed {
        logic [TOK_W-1:0]             token_rate;
        logic [3:0][USEC_W-1:0]       thr;
    } cfg_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [CLS_W-1:0] cls;
        status_t          status;
        logic [TOK_W-1:0] tokens_left;
    } res_t;

    // classes four and up share the class 3 threshold
    function automatic logic [USEC_W-1:0] thr_of(cfg_t c, logic [CLS_W-1:0] i);
        if (i < 3'd4)
            return c.thr[i[1:0]];
        return c.thr[3];
    endfunction

endpackage

`default_nettype wire

>>> rtl/pgtl_in_if.sv
// ----------------------------------------------------------------------------
// pgtl_in_if
// request / wake channel with valid-ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface pgtl_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] now_sec;
    logic [19:0] usec_in_sec;
    logic [2:0]  src_class;
    logic [15:0] tokens;
    logic [7:0]  req_tag;

    modport source (output valid, kind, now_sec, usec_in_sec, src_class, tokens, req_tag,
                    input ready);
    modport sink   (input valid, kind, now_sec, usec_in_sec, src_class, tokens, req_tag,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/pgtl_out_if.sv
// ----------------------------------------------------------------------------
// pgtl_out_if
// result channel with valid-ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface pgtl_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_tag;
    logic [2:0]  out_class;
    logic [2:0]  status;
    logic        wake_next_second;
    logic [19:0] wake_usec;
    logic [15:0] tokens_left;
    logic        last;

    modport source (output valid, out_tag, out_class, status, wake_next_second, wake_usec,
                    tokens_left, last, input ready);
    modport sink   (input valid, out_tag, out_class, status, wake_next_second, wake_usec,
                    tokens_left, last, output ready);
endinterface

`default_nettype wire

>>> rtl/pgtl_ram.sv
// ----------------------------------------------------------------------------
// pgtl_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module pgtl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

`default_nettype wire

>>> rtl/pgtl_front.sv
// ----------------------------------------------------------------------------
// pgtl_front
// accepts transactions, classifies them and holds them in a two entry queue
// ----------------------------------------------------------------------------
`default_nettype none

module pgtl_front #(
    parameter int NUM_CLASSES = pgtl_pkg::NUM_CLASSES_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    pgtl_in_if.sink             in_ch,
    output logic                cmd_valid,
    input  wire logic           cmd_ready,
    output pgtl_pkg::item_t     cmd
);
    import pgtl_pkg::*;

    item_t      buf_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;
    item_t      item;
    logic       push;
    logic       pop;

    always_comb
    begin
        item.now_sec   = in_ch.now_sec;
        item.usec      = in_ch.usec_in_sec;
        item.src_class = in_ch.src_class;
        item.tokens    = in_ch.tokens;
        item.req_tag   = in_ch.req_tag;
        if (in_ch.kind)
            item.op = OP_WAKE;
        else if (32'(in_ch.src_class) >= NUM_CLASSES)
            item.op = OP_UNLIM;
        else
            item.op = OP_REQ;
    end

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign cmd_valid   = (cnt_reg != 2'd0);
    assign cmd         = buf_reg[rptr_reg];
    assign push        = in_ch.valid && in_ch.ready;
    assign pop         = cmd_valid && cmd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                buf_reg[wptr_reg] <= item;
                wptr_reg          <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

`default_nettype wire

>>> rtl/pgtl_engine.sv
// ----------------------------------------------------------------------------
// pgtl_engine
// token bucket, class queues, wake dispatch and result delivery
// ----------------------------------------------------------------------------
`default_nettype none

module pgtl_engine #(
    parameter int QUEUE_DEPTH = pgtl_pkg::QUEUE_DEPTH_DEF,
    parameter int NUM_CLASSES = pgtl_pkg::NUM_CLASSES_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire pgtl_pkg::cfg_t cfg,
    input  wire logic           cmd_valid,
    output logic                cmd_ready,
    input  wire pgtl_pkg::item_t cmd,
    pgtl_out_if.source          out_ch
);
    import pgtl_pkg::*;

    localparam int CW    = $clog2(NUM_CLASSES);
    localparam int SW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW  = $clog2(QUEUE_DEPTH + 1);
    localparam int QAW   = CW + SW;
    localparam int QDEP  = 1 << QAW;
    localparam int RAW   = $clog2(MAX_RESULTS);
    localparam int NW    = RAW + 1;
    localparam int QEW   = TAG_W + TOK_W;
    localparam logic [CNTW-1:0] QD_C   = CNTW'(QUEUE_DEPTH);
    localparam logic [CW-1:0]   NC_M1  = CW'(NUM_CLASSES - 1);
    localparam logic [CW:0]     NC_C   = (CW + 1)'(NUM_CLASSES);
    localparam logic [NW-1:0]   MAXR_C = NW'(MAX_RESULTS);

    typedef enum logic [3:0] {
        S_IDLE, S_REFILL, S_REQ, S_CLS, S_RD, S_EV, S_NEXTV,
        S_WDONE, S_HINT, S_DRD, S_DLOAD, S_DHOLD
    } state_t;

    state_t            state_reg;
    item_t             cur_reg;
    logic [TOK_W-1:0]  avail_reg;
    logic [SEC_W-1:0]  nrs_reg;
    logic [CW-1:0]     start_reg;
    logic [CW-1:0]     v_reg;
    logic [CW-1:0]     cls_reg;
    logic [CNTW-1:0]   count_reg [NUM_CLASSES];
    logic [CNTW-1:0]   cnt_reg;
    logic [CNTW-1:0]   rd_reg;
    logic [CNTW-1:0]   wr_reg;
    logic [NW-1:0]     n_reg;
    logic [NW-1:0]     k_reg;
    logic              nxt_reg;
    logic [USEC_W-1:0] wus_reg;
    logic              out_valid_reg;
    logic              last_reg;
    res_t              out_res_reg;

    logic [CW-1:0]     cls_req;
    logic [CW:0]       cls_sum;
    logic [CW-1:0]     cls_vis;
    logic [CW-1:0]     idx_sel;
    logic [CNTW-1:0]   cnt_sel;
    logic [USEC_W-1:0] thr_sel;
    logic              grant;
    logic [TAG_W-1:0]  e_tag;
    logic [TOK_W-1:0]  e_need;
    logic              fits;
    logic [CNTW-1:0]   wr_next;
    logic              hint_nxt;
    logic [USEC_W-1:0] hint_wus;
    logic              found;
    logic [USEC_W-1:0] found_thr;

    logic              q_we;
    logic [QAW-1:0]    q_waddr;
    logic [QEW-1:0]    q_wdata;
    logic [QAW-1:0]    q_raddr;
    logic [QEW-1:0]    q_rdata;
    logic              r_we;
    res_t              r_wdata;
    res_t              r_rdata;

    pgtl_ram #(.WIDTH(QEW), .DEPTH(QDEP)) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    pgtl_ram #(.WIDTH($bits(res_t)), .DEPTH(MAX_RESULTS)) u_result_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (n_reg[RAW-1:0]),
        .wdata (r_wdata),
        .raddr (k_reg[RAW-1:0]),
        .rdata (r_rdata)
    );

    assign cls_req = cur_reg.src_class[CW-1:0];
    assign cls_sum = {1'b0, start_reg} + {1'b0, v_reg};
    assign cls_vis = (cls_sum >= NC_C) ? CW'(cls_sum - NC_C) : cls_sum[CW-1:0];
    assign idx_sel = (state_reg == S_REQ) ? cls_req : cls_vis;
    assign cnt_sel = count_reg[idx_sel];
    assign thr_sel = thr_of(cfg, CLS_W'(idx_sel));
    assign grant   = (avail_reg >= cur_reg.tokens) && (cur_reg.usec >= thr_sel)
                     && (cnt_sel == '0);
    assign e_tag   = q_rdata[QEW-1:TOK_W];
    assign e_need  = q_rdata[TOK_W-1:0];
    assign fits    = (avail_reg != '0) && (n_reg < MAXR_C) && (e_need <= avail_reg);
    assign wr_next = fits ? wr_reg : wr_reg + CNTW'(1);
    assign q_raddr = {cls_reg, rd_reg[SW-1:0]};

    // wake hint from the state left after the transaction
    always_comb
    begin
        found     = 1'b0;
        found_thr = '0;
        for (int i = 0; i < NUM_CLASSES; i++)
        begin
            if (cur_reg.usec < thr_of(cfg, CLS_W'(i)))
            begin
                found     = 1'b1;
                found_thr = thr_of(cfg, CLS_W'(i));
            end
        end
        hint_nxt = 1'b1;
        hint_wus = '0;
        if (!(cur_reg.now_sec >= nrs_reg || avail_reg == '0) && found)
        begin
            hint_nxt = 1'b0;
            hint_wus = found_thr;
        end
    end

    always_comb
    begin
        q_we    = 1'b0;
        q_waddr = {cls_reg, wr_reg[SW-1:0]};
        q_wdata = q_rdata;
        r_we    = 1'b0;
        r_wdata = '{tag: cur_reg.req_tag, cls: cur_reg.src_class, status: ST_GRANT_NOW,
                    tokens_left: avail_reg};
        unique case (state_reg)
            S_REQ:
            begin
                r_we = 1'b1;
                if (cur_reg.op == OP_REQ)
                begin
                    if (grant)
                    begin
                        r_wdata.tokens_left = avail_reg - cur_reg.tokens;
                    end
                    else if (cnt_sel < QD_C)
                    begin
                        q_we           = 1'b1;
                        q_waddr        = {cls_req, cnt_sel[SW-1:0]};
                        q_wdata        = {cur_reg.req_tag, cur_reg.tokens};
                        r_wdata.status = ST_QUEUED;
                    end
                    else
                    begin
                        r_wdata.status = ST_REJECTED;
                    end
                end
            end
            S_EV:
            begin
                q_we    = !fits;
                r_we    = fits;
                r_wdata = '{tag: e_tag, cls: CLS_W'(cls_reg), status: ST_GRANT_QUEUE,
                            tokens_left: avail_reg - e_need};
            end
            S_WDONE:
            begin
                r_we    = (n_reg == '0);
                r_wdata = '{tag: '0, cls: '0, status: ST_NONE, tokens_left: avail_reg};
            end
            default:
            begin
            end
        endcase
    end

    assign cmd_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            avail_reg     <= '0;
            nrs_reg       <= '0;
            start_reg     <= '0;
            v_reg         <= '0;
            cls_reg       <= '0;
            cnt_reg       <= '0;
            rd_reg        <= '0;
            wr_reg        <= '0;
            n_reg         <= '0;
            k_reg         <= '0;
            nxt_reg       <= 1'b0;
            wus_reg       <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
            out_res_reg   <= '0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cur_reg   <= cmd;
                        n_reg     <= '0;
                        k_reg     <= '0;
                        state_reg <= S_REFILL;
                    end
                end
                S_REFILL:
                begin
                    if (cur_reg.op != OP_UNLIM && cur_reg.now_sec >= nrs_reg)
                    begin
                        avail_reg <= cfg.token_rate;
                        nrs_reg   <= cur_reg.now_sec + 32'd1;
                    end
                    v_reg     <= '0;
                    state_reg <= (cur_reg.op == OP_WAKE) ? S_CLS : S_REQ;
                end
                S_REQ:
                begin
                    n_reg <= NW'(1);
                    if (cur_reg.op == OP_REQ)
                    begin
                        if (grant)
                            avail_reg <= avail_reg - cur_reg.tokens;
                        else if (cnt_sel < QD_C)
                            count_reg[cls_req] <= cnt_sel + CNTW'(1);
                    end
                    state_reg <= S_HINT;
                end
                S_CLS:
                begin
                    cls_reg <= cls_vis;
                    cnt_reg <= cnt_sel;
                    rd_reg  <= '0;
                    wr_reg  <= '0;
                    if (cur_reg.usec < thr_sel || cnt_sel == '0)
                        state_reg <= S_NEXTV;
                    else
                        state_reg <= S_RD;
                end
                S_RD:
                begin
                    state_reg <= S_EV;
                end
                S_EV:
                begin
                    if (fits)
                    begin
                        avail_reg <= avail_reg - e_need;
                        n_reg     <= n_reg + NW'(1);
                    end
                    wr_reg <= wr_next;
                    rd_reg <= rd_reg + CNTW'(1);
                    if (rd_reg + CNTW'(1) == cnt_reg)
                    begin
                        count_reg[cls_reg] <= wr_next;
                        state_reg          <= S_NEXTV;
                    end
                    else
                    begin
                        state_reg <= S_RD;
                    end
                end
                S_NEXTV:
                begin
                    if (v_reg == NC_M1)
                    begin
                        state_reg <= S_WDONE;
                    end
                    else
                    begin
                        v_reg     <= v_reg + CW'(1);
                        state_reg <= S_CLS;
                    end
                end
                S_WDONE:
                begin
                    start_reg <= (start_reg == NC_M1) ? '0 : start_reg + CW'(1);
                    if (n_reg == '0)
                        n_reg <= NW'(1);
                    state_reg <= S_HINT;
                end
                S_HINT:
                begin
                    nxt_reg   <= hint_nxt;
                    wus_reg   <= hint_wus;
                    state_reg <= S_DRD;
                end
                S_DRD:
                begin
                    state_reg <= S_DLOAD;
                end
                S_DLOAD:
                begin
                    out_valid_reg <= 1'b1;
                    out_res_reg   <= r_rdata;
                    last_reg      <= (k_reg + NW'(1) == n_reg);
                    state_reg     <= S_DHOLD;
                end
                S_DHOLD:
                begin
                    if (out_ch.ready)
                    begin
                        out_valid_reg <= 1'b0;
                        k_reg         <= k_reg + NW'(1);
                        state_reg     <= last_reg ? S_IDLE : S_DRD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.out_tag          = out_res_reg.tag;
    assign out_ch.out_class        = out_res_reg.cls;
    assign out_ch.status           = out_res_reg.status;
    assign out_ch.tokens_left      = out_res_reg.tokens_left;
    assign out_ch.wake_next_second = nxt_reg;
    assign out_ch.wake_usec        = wus_reg;
    assign out_ch.last             = last_reg;
endmodule

`default_nettype wire

>>> rtl/priority_gated_token_limiter.sv
// ----------------------------------------------------------------------------
// priority_gated_token_limiter
// per-second token budget shared by priority classes with queued dispatch
// ----------------------------------------------------------------------------
//  channel  | dir | handshake       | carries
//  ---------+-----+-----------------+-------------------------------------------
//  in_ch    | in  | valid / ready   | kind, now_sec, usec_in_sec, src_class, ...
//  out_ch   | out | valid / ready   | out_tag, out_class, status, wake hint, last
//  cfg      | in  | cfg_we only     | cfg_index, cfg_data (no read-back)
//
//  a request yields a single result; a wake visits every class from the rotating
//  start class, scans the entries queued in each class whose threshold is met,
//  then returns its results one by one; the queue ram read port sets the scan speed
//  the front holds two transactions, so input is taken while the back works
//  reset clears tokens, counts and the rotating start class; queue ram is
//  not cleared, only slots below a class count are ever read
`default_nettype none

module priority_gated_token_limiter #(
    parameter int QUEUE_DEPTH = pgtl_pkg::QUEUE_DEPTH_DEF,
    parameter int NUM_CLASSES = pgtl_pkg::NUM_CLASSES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    pgtl_in_if.sink                                in_ch,
    pgtl_out_if.source                             out_ch,
    input  wire logic                              cfg_we,
    input  wire logic [pgtl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pgtl_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pgtl_pkg::*;

    cfg_t   cfg_reg;
    item_t  cmd;
    logic   cmd_valid;
    logic   cmd_ready;

    // configuration registers, to be written while idle; the block itself does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.token_rate <= RATE_RST;
            cfg_reg.thr[0]     <= THR0_RST;
            cfg_reg.thr[1]     <= THR1_RST;
            cfg_reg.thr[2]     <= THR2_RST;
            cfg_reg.thr[3]     <= THR3_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TOKEN_RATE: cfg_reg.token_rate <= cfg_data[TOK_W-1:0];
                CFG_THR0:       cfg_reg.thr[0]     <= cfg_data;
                CFG_THR1:       cfg_reg.thr[1]     <= cfg_data;
                CFG_THR2:       cfg_reg.thr[2]     <= cfg_data;
                CFG_THR3:       cfg_reg.thr[3]     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // front: accept and classify, two entry queue
    pgtl_front #(.NUM_CLASSES(NUM_CLASSES)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // back: token bucket, class queues and result delivery
    pgtl_engine #(.QUEUE_DEPTH(QUEUE_DEPTH), .NUM_CLASSES(NUM_CLASSES)) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .out_ch    (out_ch)
    );

    // the no-grant result is always the only one of its wake
    a_none_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.status == ST_NONE) |-> (out_ch.last && out_ch.out_tag == '0))
        else $error("no-grant result not single");

    // requests yield exactly one result
    a_req_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && (out_ch.status == ST_GRANT_NOW || out_ch.status == ST_QUEUED ||
                          out_ch.status == ST_REJECTED)) |-> out_ch.last)
        else $error("request result not marked last");

    // after the last result the back returns to idle before the next transaction
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && out_ch.last) |=> !out_ch.valid)
        else $error("result straight after last");
endmodule

`default_nettype wire
